### rtl/page_boundary_command_splitter_defines.svh
// Assertion macros used by the page boundary command splitter checker.
// Needs clk_i and rst_ni to be visible where a macro is used.
`ifndef PAGE_BOUNDARY_COMMAND_SPLITTER_DEFINES_SVH
`define PAGE_BOUNDARY_COMMAND_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PBCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pbcs_pkg.sv
// Shared types and constants of the page boundary command splitter.
// No dependencies.
`timescale 1ns / 1ps

package pbcs_pkg;

  localparam int unsigned ADDR_W         = 48;
  localparam int unsigned LEN_W          = 26;
  localparam int unsigned PAGE_BYTES_DEF = 2097152;
  localparam int unsigned MAX_PIECES     = 33;
  localparam int unsigned CNT_W          = $clog2(MAX_PIECES);
  localparam int unsigned CFG_IDX_W      = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_VADDR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_ID   = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] request_addr;
    logic [LEN_W-1:0]  request_length;
  } pbcs_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] piece_addr;
    logic [LEN_W-1:0]  piece_length;
    logic              piece_route;
    logic              last_piece;
  } pbcs_piece_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } pbcs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
    logic piece_last;
  } pbcs_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } pbcs_state_e;

endpackage

### rtl/pbcs_ctrl.sv
// Controller of the page boundary command splitter: takes a command, then
// steps the datapath one piece per cycle while the output slot is free. Depends on pbcs_pkg.
`timescale 1ns / 1ps

module pbcs_ctrl import pbcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  pbcs_stat_t stat_i,
  output pbcs_cmd_t  cmd_o
);

  pbcs_state_e state_q, state_d;

  // Sequence load and piece emission
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.piece_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/pbcs_dp.sv
// Datapath of the page boundary command splitter: configuration registers,
// command state, piece arithmetic and the output register. Depends on pbcs_pkg.
`timescale 1ns / 1ps

module pbcs_dp import pbcs_pkg::*; #(
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  pbcs_req_t            in_data_i,
  input  pbcs_cmd_t            cmd_i,
  output pbcs_stat_t           stat_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pbcs_piece_t          out_data_o
);

  localparam int unsigned      PAGE_W   = $clog2(PAGE_BYTES);
  localparam logic [LEN_W-1:0] PAGE_LEN = LEN_W'(PAGE_BYTES);
  localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(MAX_PIECES - 1);

  logic [PAGE_W-1:0] base_q;
  logic              route_q;
  logic [ADDR_W-1:0] addr_q;
  logic [LEN_W-1:0]  rem_q;
  logic [LEN_W-1:0]  first_len_q, first_len_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              first_q;
  logic              fits_q, fits_d;
  logic              out_valid_q;
  pbcs_piece_t       out_q;

  logic [PAGE_W-1:0] off_in;
  logic              more;
  logic [LEN_W-1:0]  piece_len;
  logic              piece_last;

  // Page offset of the incoming command and its first piece
  always_comb begin
    off_in      = in_data_i.request_addr[PAGE_W-1:0] - base_q;
    fits_d      = ({1'b0, in_data_i.request_length} + (LEN_W+1)'(off_in))
                  <= {1'b0, PAGE_LEN};
    first_len_d = fits_d ? in_data_i.request_length : PAGE_LEN - LEN_W'(off_in);
  end

  // Length and end mark of the piece now due
  always_comb begin
    more       = (rem_q > PAGE_LEN) && (cnt_q < CNT_CAP);
    piece_len  = first_q ? first_len_q : (more ? PAGE_LEN : rem_q);
    piece_last = first_q ? fits_q : !more;
  end

  assign stat_o.slot_free  = !out_valid_q || !out_stall_i;
  assign stat_o.piece_last = piece_last;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      route_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BASE_VADDR: base_q  <= cfg_data_i[PAGE_W-1:0];
        CFG_ROUTE_ID:   route_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Command state: load on accept, advance on each emitted piece
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q      <= in_data_i.request_addr;
      rem_q       <= in_data_i.request_length;
      first_len_q <= first_len_d;
      fits_q      <= fits_d;
      cnt_q       <= '0;
    end else if (cmd_i.emit) begin
      addr_q <= addr_q + ADDR_W'(piece_len);
      rem_q  <= rem_q - piece_len;
      cnt_q  <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b0;
    end else if (cmd_i.load) begin
      first_q <= 1'b1;
    end else if (cmd_i.emit) begin
      first_q <= 1'b0;
    end
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.piece_addr   <= addr_q;
      out_q.piece_length <= piece_len;
      out_q.piece_route  <= route_q;
      out_q.last_piece   <= piece_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/page_boundary_command_splitter.sv
// Page boundary command splitter: one command beat in, one beat per piece out.
// A command is loaded into the command state, then each piece passes through
// the piece step of the datapath; a stalled output holds that step. The first
// piece is registered at the output after the load, once the output slot is free;
// the input stalls until the last piece is in the output register.
// Reset clears control state and the configuration registers (base 0, route 0).
`timescale 1ns / 1ps

module page_boundary_command_splitter import pbcs_pkg::*; #(
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pbcs_req_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pbcs_piece_t          out_data_o
);

  pbcs_cmd_t  cmd;
  pbcs_stat_t stat;

  pbcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pbcs_dp #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/pbcs_checker.sv
// Port-level checker of the page boundary command splitter, bound to the top.
// Depends on pbcs_pkg and page_boundary_command_splitter_defines.svh.
`timescale 1ns / 1ps
`include "page_boundary_command_splitter_defines.svh"

module pbcs_checker import pbcs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input pbcs_piece_t out_data_o
);

  logic in_beat;
  logic out_wait;
  logic out_mid;
  logic out_empty;

  assign in_beat   = in_valid_i && !in_stall_o;
  assign out_wait  = out_valid_o && out_stall_i;
  assign out_mid   = out_valid_o && !out_data_o.last_piece;
  assign out_empty = out_valid_o && (out_data_o.piece_length == '0);

  // A stalled result beat holds
  `PBCS_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable(out_data_o), "held beat changed")

  // One command at a time: busy right after a command beat
  `PBCS_ASSERT_NEXT(a_busy_after_cmd, in_beat, in_stall_o, "command taken while splitting")

  // A piece that is not the last one leaves the block busy
  `PBCS_ASSERT_NOW(a_busy_mid_cmd, out_mid, in_stall_o, "ready before last piece")

  // Only a final piece may be empty
  `PBCS_ASSERT_NOW(a_empty_is_last, out_empty, out_data_o.last_piece, "empty piece not last")

endmodule

bind page_boundary_command_splitter pbcs_checker u_pbcs_checker (.*);
